@@ hw/rtl/jcl_pkg.sv @@
// jcl_pkg: shared types, mode codes and display/coil tables for the joystick combination lock
// no dependencies; imported by every module of the block
package jcl_pkg;

   // widths
   localparam int SAMPLE_BITS = 10;
   localparam int THR_BITS    = 10;
   localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
   localparam int REV_BITS    = 10;
   localparam int CODE_BITS   = 8;
   localparam int NUM_MOVES   = 4;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 10;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PASSCODE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH_THR  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW_THR   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REVS      = 2'd3;

   // register reset values
   localparam logic [CODE_BITS-1:0] PASSCODE_RST = 8'd228;
   localparam logic [THR_BITS-1:0]  HIGH_THR_RST = 10'd600;
   localparam logic [THR_BITS-1:0]  LOW_THR_RST  = 10'd450;
   localparam logic [REV_BITS-1:0]  REVS_RST     = 10'd128;

   // mode codes
   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_UP     = 3'd1;
   localparam logic [2:0] MODE_DOWN   = 3'd2;
   localparam logic [2:0] MODE_LEFT   = 3'd3;
   localparam logic [2:0] MODE_RIGHT  = 3'd4;
   localparam logic [2:0] MODE_CHECK  = 3'd5;
   localparam logic [2:0] MODE_UNLOCK = 3'd6;
   localparam logic [2:0] MODE_LOCK   = 3'd7;

   // move codes
   localparam logic [1:0] MOVE_UP    = 2'd0;
   localparam logic [1:0] MOVE_DOWN  = 2'd1;
   localparam logic [1:0] MOVE_LEFT  = 2'd2;
   localparam logic [1:0] MOVE_RIGHT = 2'd3;

   localparam logic [2:0] MAX_MOVES = 3'd4;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] vertical_sample;
      logic [SAMPLE_BITS-1:0] horizontal_sample;
   } req_type;

   typedef struct packed {
      logic [6:0] segments;
      logic       decimal_point;
      logic [3:0] coil_pattern;
      logic [2:0] move_count;
      logic       locked;
      logic       motor_busy;
   } rsp_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] passcode;
      logic [THR_BITS-1:0]  high_threshold;
      logic [THR_BITS-1:0]  low_threshold;
      logic [REV_BITS-1:0]  revolutions;
   } cfg_type;

   // digit patterns 0..4, clamped at 4
   function automatic logic [6:0] digit_seg(input logic [2:0] n);
      logic [6:0] s;
      case (n)
         3'd0:    s = 7'h7E;
         3'd1:    s = 7'h30;
         3'd2:    s = 7'h6D;
         3'd3:    s = 7'h79;
         default: s = 7'h33;
      endcase
      return s;
   endfunction

   // direction letters U d L r
   function automatic logic [6:0] dir_seg(input logic [1:0] d);
      logic [6:0] s;
      case (d)
         MOVE_UP:   s = 7'h3E;
         MOVE_DOWN: s = 7'h3D;
         MOVE_LEFT: s = 7'h0E;
         default:   s = 7'h05;
      endcase
      return s;
   endfunction

   // forward half-step coil sequence
   function automatic logic [3:0] fwd_phase(input logic [2:0] p);
      logic [3:0] c;
      case (p)
         3'd0:    c = 4'b0001;
         3'd1:    c = 4'b0011;
         3'd2:    c = 4'b0010;
         3'd3:    c = 4'b0110;
         3'd4:    c = 4'b0100;
         3'd5:    c = 4'b1100;
         3'd6:    c = 4'b1000;
         default: c = 4'b1001;
      endcase
      return c;
   endfunction

endpackage

@@ hw/rtl/jcl_csr.sv @@
// jcl_csr: configuration registers of the joystick combination lock
// depends on jcl_pkg for the register indexes, reset values and cfg_type
module jcl_csr import jcl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PASSCODE: cfg_in.passcode       = csr_wdata[CODE_BITS-1:0];
            CSR_HIGH_THR: cfg_in.high_threshold = csr_wdata[THR_BITS-1:0];
            CSR_LOW_THR:  cfg_in.low_threshold  = csr_wdata[THR_BITS-1:0];
            CSR_REVS:     cfg_in.revolutions    = csr_wdata[REV_BITS-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.passcode       <= PASSCODE_RST;
         cfg_ff.high_threshold <= HIGH_THR_RST;
         cfg_ff.low_threshold  <= LOW_THR_RST;
         cfg_ff.revolutions    <= REVS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/jcl_core.sv @@
// jcl_core: lock state and one-tick step logic (move entry, check, stepper turning)
// depends on jcl_pkg for mode codes, tables and payload types
module jcl_core import jcl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type sample,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [2:0]          mode_ff, mode_in;
   logic [1:0]          moves_ff [NUM_MOVES];
   logic [2:0]          count_ff, count_in;
   logic                unlocked_ff, unlocked_in;
   logic [2:0]          phase_ff, phase_in;
   logic [REV_BITS-1:0] rev_ff, rev_in;
   logic [6:0]          seg_ff, seg_in;
   logic [3:0]          coil_ff, coil_in;

   logic                store_en;
   logic [1:0]          store_code;

   logic [CMP_BITS-1:0] v_ext, h_ext, hi_ext, lo_ext;
   logic                v_hi, v_lo, h_hi, h_lo;
   logic                pass;
   logic [2:0]          mode_mid;
   logic [2:0]          count_mid;
   logic [2:0]          phase_mid;
   logic [REV_BITS-1:0] rev_mid;
   logic                fwd;
   logic [2:0]          p_sel;
   logic                busy, dp;
   logic [REV_BITS-1:0] rev_inc;

   // threshold compares
   assign v_ext  = CMP_BITS'(sample.vertical_sample);
   assign h_ext  = CMP_BITS'(sample.horizontal_sample);
   assign hi_ext = CMP_BITS'(cfg.high_threshold);
   assign lo_ext = CMP_BITS'(cfg.low_threshold);
   assign v_hi   = v_ext >= hi_ext;
   assign v_lo   = v_ext <= lo_ext;
   assign h_hi   = h_ext >= hi_ext;
   assign h_lo   = h_ext <= lo_ext;

   // passcode match over the four stored moves
   always_comb begin
      pass = 1'b1;
      for (int k = 0; k < NUM_MOVES; k++) begin
         if (moves_ff[k] != cfg.passcode[2*k +: 2]) pass = 1'b0;
      end
   end

   // entry and check
   always_comb begin
      mode_mid    = mode_ff;
      count_mid   = count_ff;
      phase_mid   = phase_ff;
      rev_mid     = rev_ff;
      store_en    = 1'b0;
      store_code  = MOVE_UP;
      case (mode_ff)
         MODE_IDLE: begin
            if (count_ff >= MAX_MOVES) mode_mid = MODE_CHECK;
            else if (v_hi)             mode_mid = MODE_UP;
            else if (v_lo)             mode_mid = MODE_DOWN;
            else if (h_lo)             mode_mid = MODE_LEFT;
            else if (h_hi)             mode_mid = MODE_RIGHT;
         end
         MODE_UP: begin
            if (!v_hi) begin
               store_en   = 1'b1;
               store_code = MOVE_UP;
            end
         end
         MODE_DOWN: begin
            if (!v_lo) begin
               store_en   = 1'b1;
               store_code = MOVE_DOWN;
            end
         end
         MODE_LEFT: begin
            if (!h_lo) begin
               store_en   = 1'b1;
               store_code = MOVE_LEFT;
            end
         end
         MODE_RIGHT: begin
            if (!h_hi) begin
               store_en   = 1'b1;
               store_code = MOVE_RIGHT;
            end
         end
         MODE_CHECK: begin
            count_mid = '0;
            if (pass) begin
               mode_mid  = unlocked_ff ? MODE_LOCK : MODE_UNLOCK;
               phase_mid = '0;
               rev_mid   = '0;
            end else begin
               mode_mid = MODE_IDLE;
            end
         end
         MODE_UNLOCK, MODE_LOCK: mode_mid = mode_ff;
         default: mode_mid = MODE_IDLE;
      endcase
      if (store_en) begin
         mode_mid = MODE_IDLE;
         if (count_ff < MAX_MOVES) count_mid = count_ff + 3'd1;
      end
   end

   // display and stepper drive
   always_comb begin
      mode_in     = mode_mid;
      count_in    = count_mid;
      phase_in    = phase_mid;
      rev_in      = rev_mid;
      unlocked_in = unlocked_ff;
      seg_in      = seg_ff;
      coil_in     = coil_ff;
      busy        = 1'b0;
      dp          = ~unlocked_ff;
      fwd         = (mode_mid == MODE_UNLOCK);
      p_sel       = fwd ? phase_mid : (3'd7 - phase_mid);
      rev_inc     = (rev_mid != '1) ? rev_mid + REV_BITS'(1) : rev_mid;
      case (mode_mid)
         MODE_IDLE:  seg_in = digit_seg(count_mid);
         MODE_UP:    seg_in = dir_seg(MOVE_UP);
         MODE_DOWN:  seg_in = dir_seg(MOVE_DOWN);
         MODE_LEFT:  seg_in = dir_seg(MOVE_LEFT);
         MODE_RIGHT: seg_in = dir_seg(MOVE_RIGHT);
         MODE_CHECK: dp = 1'b1;
         default: begin
            coil_in  = fwd_phase(p_sel);
            busy     = 1'b1;
            dp       = ~fwd;
            phase_in = phase_mid + 3'd1;
            if (phase_in == 3'd0) begin
               rev_in = rev_inc;
               if (rev_inc >= cfg.revolutions) begin
                  unlocked_in = fwd;
                  count_in    = '0;
                  rev_in      = '0;
                  mode_in     = MODE_IDLE;
               end
            end
         end
      endcase
   end

   assign result.segments      = seg_in;
   assign result.decimal_point = dp;
   assign result.coil_pattern  = coil_in;
   assign result.move_count    = count_in;
   assign result.locked        = ~unlocked_in;
   assign result.motor_busy    = busy;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         count_ff    <= '0;
         unlocked_ff <= 1'b0;
         phase_ff    <= '0;
         rev_ff      <= '0;
         seg_ff      <= '0;
         coil_ff     <= '0;
      end else if (step_en) begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         unlocked_ff <= unlocked_in;
         phase_ff    <= phase_in;
         rev_ff      <= rev_in;
         seg_ff      <= seg_in;
         coil_ff     <= coil_in;
      end
   end

   // move store, undefined until written
   always_ff @(posedge clock) begin
      if (step_en && store_en && (count_ff < MAX_MOVES)) begin
         moves_ff[count_ff[1:0]] <= store_code;
      end
   end

endmodule

@@ hw/rtl/joystick_combination_lock_top.sv @@
// joystick_combination_lock_top: top level with input register, result register and csr block
// depends on jcl_pkg, jcl_csr and jcl_core
//
// Joystick combination lock. Each transfer on req_ carries one tick of joystick samples
// and yields exactly one transfer on rsp_ with the display, lock and coil outputs for that
// tick. One item is taken every cycle while req_stall is low. An item is held in the input
// register, and its result is loaded into the result register when the step logic advances
// and is offered on rsp_ from then on. A held rsp_stall fills both registers, after which
// req_stall rises. The user must write configuration through csr_ only while no item is in
// flight; the block itself does not enforce this.
module joystick_combination_lock_top import jcl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    req_xfer, advance;
   cfg_type cfg;
   rsp_type step_result;

   jcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jcl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .sample  (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // handshake control
   assign advance      = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall    = in_valid_ff & ~advance;
   assign req_xfer     = req_valid & ~req_stall;
   assign in_valid_in  = req_xfer | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) in_data_ff  <= req_data;
      if (advance)  out_data_ff <= step_result;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ hw/rtl/jcl_checker.sv @@
// jcl_checker: port-level assertions for the joystick combination lock, bound to the top level
// depends on jcl_pkg and joystick_combination_lock_top
module jcl_checker import jcl_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input req_type                  req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input rsp_type                  rsp_data,
   input logic                     csr_we,
   input logic [CSR_IDX_BITS-1:0]  csr_index,
   input logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // move count never passes four
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.move_count <= MAX_MOVES)
      else $error("move count out of range");

   // turning only starts after the check cleared the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motor_busy |-> rsp_data.move_count == 3'd0)
      else $error("motor busy with moves pending");

   // a driven half-step energizes one or two coils
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motor_busy |->
         ($countones(rsp_data.coil_pattern) == 1) || ($countones(rsp_data.coil_pattern) == 2))
      else $error("bad coil pattern");

   // no stall on input while the result side is free
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind joystick_combination_lock_top jcl_checker u_jcl_checker (.*);

@@ test/testbench.sv @@
// testbench for joystick_combination_lock_top: directed entry, then random move sequences
// needs jcl_pkg and the block's rtl; a scoreboard class predicts every result transfer
`timescale 1ns / 1ps

module testbench;
   import jcl_pkg::*;

   localparam int STALL_LIMIT = 2000;

   // tracks lock state from accepted samples and checks each result transfer
   class lock_checker;
      cfg_type         regs;
      logic [2:0]      mode;
      logic [1:0]      moves [NUM_MOVES];
      logic [2:0]      count;
      logic            unlocked;
      logic [2:0]      phase;
      logic [9:0]      turns;
      logic [6:0]      seg_hold;
      logic [3:0]      coil_hold;
      logic [4:0][6:0] digit_pat;
      logic [3:0][6:0] letter_pat;
      logic [7:0][3:0] coil_seq;
      rsp_type         outputs_due [$];
      int unsigned     fails;
      int unsigned     checked;

      function new();
         digit_pat  = {7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E};
         letter_pat = {7'h05, 7'h0E, 7'h3D, 7'h3E};
         coil_seq   = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};
         regs.passcode       = PASSCODE_RST;
         regs.high_threshold = HIGH_THR_RST;
         regs.low_threshold  = LOW_THR_RST;
         regs.revolutions    = REVS_RST;
         mode = MODE_IDLE;
         foreach (moves[k]) moves[k] = MOVE_UP;
         count     = '0;
         unlocked  = 1'b0;
         phase     = '0;
         turns     = '0;
         seg_hold  = '0;
         coil_hold = '0;
         fails     = 0;
         checked   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_PASSCODE: regs.passcode       = val[CODE_BITS-1:0];
            CSR_HIGH_THR: regs.high_threshold = val[THR_BITS-1:0];
            CSR_LOW_THR:  regs.low_threshold  = val[THR_BITS-1:0];
            default:      regs.revolutions    = val[REV_BITS-1:0];
         endcase
      endfunction

      // samples have no effect while checking, turning or about to check
      function bit ignoring();
         return (mode == MODE_CHECK) || (mode == MODE_UNLOCK) || (mode == MODE_LOCK) ||
                (mode == MODE_IDLE && count >= MAX_MOVES);
      endfunction

      function int pending();
         return outputs_due.size();
      endfunction

      function void store_move(logic [1:0] code);
         if (count < MAX_MOVES) begin
            moves[count[1:0]] = code;
            count = count + 3'd1;
         end
         mode = MODE_IDLE;
      endfunction

      // one tick of the lock: state update, then display and coil outputs
      function rsp_type step_lock(req_type r);
         logic [SAMPLE_BITS-1:0] v;
         logic [SAMPLE_BITS-1:0] h;
         logic                   fwd;
         logic                   dp;
         logic                   busy;
         logic                   hit;
         logic [2:0]             p;
         rsp_type                o;
         v    = r.vertical_sample;
         h    = r.horizontal_sample;
         busy = 1'b0;
         case (mode)
            MODE_IDLE: begin
               if (count >= MAX_MOVES) mode = MODE_CHECK;
               else if (v >= regs.high_threshold) mode = MODE_UP;
               else if (v <= regs.low_threshold) mode = MODE_DOWN;
               else if (h <= regs.low_threshold) mode = MODE_LEFT;
               else if (h >= regs.high_threshold) mode = MODE_RIGHT;
            end
            MODE_UP:    if (v < regs.high_threshold) store_move(MOVE_UP);
            MODE_DOWN:  if (v > regs.low_threshold) store_move(MOVE_DOWN);
            MODE_LEFT:  if (h > regs.low_threshold) store_move(MOVE_LEFT);
            MODE_RIGHT: if (h < regs.high_threshold) store_move(MOVE_RIGHT);
            MODE_CHECK: begin
               hit = 1'b1;
               for (int k = 0; k < NUM_MOVES; k++)
                  if (moves[k] != regs.passcode[2*k +: 2]) hit = 1'b0;
               count = '0;
               if (hit) begin
                  mode  = unlocked ? MODE_LOCK : MODE_UNLOCK;
                  phase = '0;
                  turns = '0;
               end else begin
                  mode = MODE_IDLE;
               end
            end
            default: ;
         endcase

         dp = !unlocked;
         case (mode)
            MODE_IDLE:  seg_hold = digit_pat[(count > MAX_MOVES) ? MAX_MOVES : count];
            MODE_UP:    seg_hold = letter_pat[MOVE_UP];
            MODE_DOWN:  seg_hold = letter_pat[MOVE_DOWN];
            MODE_LEFT:  seg_hold = letter_pat[MOVE_LEFT];
            MODE_RIGHT: seg_hold = letter_pat[MOVE_RIGHT];
            MODE_CHECK: dp = 1'b1;
            default: begin
               // stepper turning: forward to unlock, reverse to lock
               fwd       = (mode == MODE_UNLOCK);
               p         = phase;
               coil_hold = fwd ? coil_seq[p] : coil_seq[3'd7 - p];
               busy      = 1'b1;
               dp        = !fwd;
               phase     = p + 3'd1;
               if (phase == 3'd0) begin
                  if (turns != 10'h3FF) turns = turns + 10'd1;
                  // a revolution count of zero ends after the first revolution
                  if (turns >= regs.revolutions) begin
                     unlocked = fwd;
                     count    = '0;
                     turns    = '0;
                     mode     = MODE_IDLE;
                  end
               end
            end
         endcase

         o.segments      = seg_hold;
         o.decimal_point = dp;
         o.coil_pattern  = coil_hold;
         o.move_count    = count;
         o.locked        = !unlocked;
         o.motor_busy    = busy;
         return o;
      endfunction

      // returns 1 when the sample could affect the lock
      function bit take_sample(req_type r);
         bit acted;
         acted = !ignoring();
         outputs_due.push_back(step_lock(r));
         return acted;
      endfunction

      task report(string what);
         if (fails < 100) $display("MISMATCH: %s", what);
         fails++;
      endtask

      task compare_output(rsp_type got);
         rsp_type want;
         if (outputs_due.size() == 0) begin
            report($sformatf("result transfer %0d arrived with nothing expected", checked));
         end else begin
            want = outputs_due.pop_front();
            if (got.segments !== want.segments)
               report($sformatf("transfer %0d segments %h, expected %h",
                                checked, got.segments, want.segments));
            if (got.decimal_point !== want.decimal_point)
               report($sformatf("transfer %0d decimal_point %b, expected %b",
                                checked, got.decimal_point, want.decimal_point));
            if (got.coil_pattern !== want.coil_pattern)
               report($sformatf("transfer %0d coil_pattern %h, expected %h",
                                checked, got.coil_pattern, want.coil_pattern));
            if (got.move_count !== want.move_count)
               report($sformatf("transfer %0d move_count %0d, expected %0d",
                                checked, got.move_count, want.move_count));
            if (got.locked !== want.locked)
               report($sformatf("transfer %0d locked %b, expected %b",
                                checked, got.locked, want.locked));
            if (got.motor_busy !== want.motor_busy)
               report($sformatf("transfer %0d motor_busy %b, expected %b",
                                checked, got.motor_busy, want.motor_busy));
         end
         checked++;
      endtask
   endclass

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   lock_checker tracker = new();
   int          send_gap_pct   = 33;
   int          recv_stall_pct = 77;
   int          samples_used   = 0;
   int          quiet_cycles   = 0;

   joystick_combination_lock_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) tracker.compare_output(rsp_data);
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // sample values relative to the current thresholds
   function automatic logic [SAMPLE_BITS-1:0] above_high();
      return SAMPLE_BITS'($urandom_range(1023, tracker.regs.high_threshold));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] below_low();
      return SAMPLE_BITS'($urandom_range(tracker.regs.low_threshold, 0));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] between();
      int lo_v;
      int hi_v;
      lo_v = tracker.regs.low_threshold;
      hi_v = tracker.regs.high_threshold;
      if (hi_v > lo_v + 1) return SAMPLE_BITS'($urandom_range(hi_v - 1, lo_v + 1));
      return SAMPLE_BITS'($urandom_range(1023, 0));
   endfunction

   function automatic req_type noise();
      req_type r;
      r.vertical_sample   = SAMPLE_BITS'($urandom_range(1023, 0));
      r.horizontal_sample = SAMPLE_BITS'($urandom_range(1023, 0));
      return r;
   endfunction

   function automatic req_type centered();
      req_type r;
      r.vertical_sample   = between();
      r.horizontal_sample = between();
      return r;
   endfunction

   function automatic req_type deflect(logic [1:0] dir);
      req_type r;
      r = noise();
      case (dir)
         MOVE_UP:   r.vertical_sample = above_high();
         MOVE_DOWN: r.vertical_sample = below_low();
         MOVE_LEFT: begin
            r.vertical_sample   = between();
            r.horizontal_sample = below_low();
         end
         default: begin
            r.vertical_sample   = between();
            r.horizontal_sample = above_high();
         end
      endcase
      return r;
   endfunction

   // one input transfer, with random sender gaps ahead of it
   task automatic send_req(req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      void'(tracker.take_sample(r));
      samples_used++;
   endtask

   task automatic send_pair(int v, int h);
      req_type r;
      r.vertical_sample   = SAMPLE_BITS'(v);
      r.horizontal_sample = SAMPLE_BITS'(h);
      send_req(r);
   endtask

   task automatic enter_move(logic [1:0] dir);
      int n;
      n = $urandom_range(3, 1);
      repeat (n) send_req(deflect(dir));
      n = $urandom_range(2, 1);
      repeat (n) send_req(centered());
   endtask

   // moves from the passcode, or random ones
   task automatic try_code(bit follow, int n_moves);
      logic [1:0] dir;
      for (int k = 0; k < n_moves; k++) begin
         dir = follow ? tracker.regs.passcode[2*k +: 2] : 2'($urandom_range(3, 0));
         enter_move(dir);
      end
   endtask

   // noise while the lock checks or turns
   task automatic settle();
      while (tracker.ignoring()) send_req(noise());
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.write_reg(idx, val);
      @(negedge clock);
   endtask

   // register writes only once every result has come back
   task automatic apply_cfg(logic [7:0] pc, logic [9:0] hi, logic [9:0] lo, logic [9:0] rv);
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      write_reg(CSR_PASSCODE, CSR_DATA_BITS'(pc));
      write_reg(CSR_HIGH_THR, hi);
      write_reg(CSR_LOW_THR, lo);
      write_reg(CSR_REVS, rv);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int target, int gap_pct, int stall_pct);
      int goal;
      int r;
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      goal = samples_used + target;
      while (samples_used < goal) begin
         if (tracker.ignoring()) begin
            send_req(noise());
         end else begin
            r = $urandom_range(99);
            if (r < 65) begin
               try_code(1'b1, NUM_MOVES);
            end else if (r < 80) begin
               try_code(1'b0, NUM_MOVES);
            end else if (r < 90) begin
               // partial code broken off by noise
               try_code(1'b1, $urandom_range(3, 1));
               repeat ($urandom_range(3, 1)) send_req(noise());
            end else begin
               repeat ($urandom_range(4, 1)) send_req(noise());
            end
         end
      end
   endtask

   // entry with reset thresholds and passcode: axis priority, inclusive thresholds,
   // unlock, wrong code
   task automatic entry_walkthrough();
      send_pair(512, 512);
      send_pair(1023, 0);
      send_pair(1023, 1023);
      send_pair(599, 512);
      send_pair(0, 1023);
      send_pair(450, 0);
      send_pair(451, 512);
      send_pair(599, 450);
      send_pair(599, 451);
      send_pair(451, 600);
      send_pair(512, 599);
      send_pair(1023, 1023);
      send_pair(0, 0);
      settle();
      repeat (NUM_MOVES) begin
         send_pair(600, 512);
         send_pair(512, 512);
      end
      settle();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // short turns keep the run near its item budget
      write_reg(CSR_REVS, CSR_DATA_BITS'(2));
      csr_we <= 1'b0;

      entry_walkthrough();
      run_phase(150, 33, 77);
      apply_cfg(8'($urandom_range(255, 0)), 10'd600, 10'd450, 10'd0);
      run_phase(200, 33, 77);
      apply_cfg(8'd0, 10'd1023, 10'd0, 10'd1);
      run_phase(150, 33, 77);
      apply_cfg(8'd255, 10'd513, 10'd511, 10'd2);
      run_phase(200, 77, 33);
      // every sample counts as up, so the stick never returns
      apply_cfg(8'($urandom_range(255, 0)), 10'd0, 10'd1023, 10'd1);
      run_phase(60, 77, 33);
      apply_cfg(8'($urandom_range(255, 0)), 10'($urandom_range(900, 520)),
                10'($urandom_range(500, 100)), 10'd1023);
      run_phase(30, 77, 33);
      apply_cfg(8'($urandom_range(255, 0)), 10'($urandom_range(1023, 0)),
                10'($urandom_range(1023, 0)), 10'($urandom_range(5, 1)));
      run_phase(200, 0, 0);
      apply_cfg(8'($urandom_range(255, 0)), 10'd700, 10'd300, 10'd3);
      run_phase(170, 0, 0);

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (tracker.fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
